>>> hdl/cbbr_pkg.sv
// Shared types, region codes and constants for the cartridge bridge bank registers.
// No dependencies; every module of the block imports this package.
`default_nettype none
package cbbr_pkg;

	localparam logic [14:0] ADDR_CTRL_END   = 15'h1fff;
	localparam logic [14:0] ADDR_BANK_END   = 15'h2fff;
	localparam logic [14:0] ADDR_ENABLE_END = 15'h3fff;
	localparam logic [7:0]  CODE_ON         = 8'h84;
	localparam logic [7:0]  CODE_OFF        = 8'hfe;
	localparam logic [1:0]  BANK_ON         = 2'd3;
	localparam logic [1:0]  PHASE_START     = 2'd3;
	localparam logic [7:0]  BANK_MAX        = 8'd3;

	typedef enum logic [1:0] {
		REGION_CTRL,
		REGION_BANK,
		REGION_ENABLE,
		REGION_WINDOW
	} region_t;

	typedef enum logic {
		MODE_READ  = 1'b0,
		MODE_WRITE = 1'b1
	} mode_t;

	typedef struct packed {
		logic        cart_present;
		logic [7:0]  cart_read_data;
		logic [7:0]  write_data;
		logic [15:0] address;
		mode_t       mode;
	} in_item_t;

	typedef struct packed {
		logic        cart_power;
		logic        cart_write;
		logic        cart_read;
		logic [15:0] cart_address;
		logic [7:0]  read_data;
	} out_item_t;

	typedef struct packed {
		logic     valid;
		in_item_t item;
	} in_beat_t;

	function automatic region_t region_of(input logic [14:0] a);
		region_t r;
		if (a <= ADDR_CTRL_END) begin
			r = REGION_CTRL;
		end else if (a <= ADDR_BANK_END) begin
			r = REGION_BANK;
		end else if (a <= ADDR_ENABLE_END) begin
			r = REGION_ENABLE;
		end else begin
			r = REGION_WINDOW;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> hdl/cbbr_in_stage.sv
// Input register stage of the cartridge bridge: captures one access beat.
// Depends on cbbr_pkg for the item types.
`default_nettype none
module cbbr_in_stage (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  cbbr_pkg::in_item_t in_item,
	input  wire                advance,
	output cbbr_pkg::in_beat_t beat_s1
);
	import cbbr_pkg::*;

	logic     valid_s1;
	in_item_t item_s1;

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	assign beat_s1 = '{valid: valid_s1, item: item_s1};

endmodule
`default_nettype wire

>>> hdl/cbbr_decode.sv
// Address decode and bank/enable/status registers of the cartridge bridge.
// Depends on cbbr_pkg; state advances only when an access leaves the input stage.
`default_nettype none
module cbbr_decode (
	input  wire                 clk,
	input  wire                 arst_n,
	input  cbbr_pkg::in_item_t  item,
	input  wire                 advance,
	output cbbr_pkg::out_item_t result
);
	import cbbr_pkg::*;

	logic       bridge_on_q, bridge_on_d;
	logic [1:0] bank_q, bank_d;
	logic       cart_on_q, cart_on_d;
	logic [1:0] reset_phase_q, reset_phase_d;

	logic [14:0] a;
	region_t     region;
	logic [15:0] window_addr;

	assign a           = item.address[14:0];
	assign region      = region_of(a);
	assign window_addr = {bank_q, a[13:0]};

	always_comb begin
		bridge_on_d   = bridge_on_q;
		bank_d        = bank_q;
		cart_on_d     = cart_on_q;
		reset_phase_d = reset_phase_q;
		result        = '0;
		if (item.mode == MODE_WRITE) begin
			if (region == REGION_CTRL) begin
				if (item.write_data == CODE_ON) begin
					bridge_on_d = 1'b1;
					if (!bridge_on_q) begin
						bank_d        = BANK_ON;
						cart_on_d     = 1'b0;
						reset_phase_d = '0;
					end
				end else if (item.write_data == CODE_OFF) begin
					bridge_on_d = 1'b0;
				end
			end else if (bridge_on_q) begin
				case (region)
					REGION_BANK: begin
						bank_d = (item.write_data > BANK_MAX) ? 2'd0 : item.write_data[1:0];
					end
					REGION_ENABLE: begin
						cart_on_d = item.write_data[0];
						if (!cart_on_q && item.write_data[0]) begin
							reset_phase_d     = PHASE_START;
							result.cart_power = 1'b1;
						end
					end
					default: begin
						if (cart_on_q) begin
							result.cart_address = window_addr;
							result.cart_write   = 1'b1;
						end
					end
				endcase
			end
		end else if (bridge_on_q) begin
			case (region)
				REGION_CTRL: begin
					result.read_data = CODE_ON;
				end
				REGION_BANK: begin
					result.read_data = {6'd0, bank_q};
				end
				REGION_ENABLE: begin
					result.read_data = {1'b1, !item.cart_present, 2'b00,
						reset_phase_q, 1'b0, cart_on_q};
					// step the power-up sequence on status reads
					if (cart_on_q && reset_phase_q == 2'd3) begin
						reset_phase_d = 2'd2;
					end else if (!cart_on_q && reset_phase_q != 2'd0
						&& reset_phase_q != 2'd3) begin
						reset_phase_d = reset_phase_q - 2'd1;
					end
				end
				default: begin
					if (cart_on_q) begin
						result.cart_address = window_addr;
						result.cart_read    = 1'b1;
						result.read_data    = item.cart_read_data;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bridge_on_q   <= 1'b0;
			bank_q        <= '0;
			cart_on_q     <= 1'b0;
			reset_phase_q <= '0;
		end else if (advance) begin
			bridge_on_q   <= bridge_on_d;
			bank_q        <= bank_d;
			cart_on_q     <= cart_on_d;
			reset_phase_q <= reset_phase_d;
		end
	end

endmodule
`default_nettype wire

>>> hdl/cbbr_out_stage.sv
// Result register of the cartridge bridge: holds one result beat until taken.
// Depends on cbbr_pkg for the result type.
`default_nettype none
module cbbr_out_stage (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 load,
	input  cbbr_pkg::out_item_t result,
	output logic                out_valid,
	input  wire                 out_ready,
	output cbbr_pkg::out_item_t out_item
);
	import cbbr_pkg::*;

	logic      valid_s2;
	out_item_t item_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign out_item  = item_s2;

endmodule
`default_nettype wire

>>> hdl/cartridge_bridge_bank_registers.sv
// Top level of the cartridge bridge bank registers: input stage, decode, result stage.
// Depends on cbbr_pkg, cbbr_in_stage, cbbr_decode and cbbr_out_stage.
//
//  channel | dir | handshake                 | payload
//  --------+-----+---------------------------+-------------------------------------------
//  s_axis  | in  | s_axis_tvalid/tready      | tdata: address, write_data, cart_read_data,
//          |     |                           |        cart_present; tuser: mode
//  m_axis  | out | m_axis_tvalid/tready      | tdata: read_data, cart_address, cart_read,
//          |     |                           |        cart_write, cart_power
//
// One access per cycle sustained while m_axis_tready stays high; each beat passes through the
// input register, then is decoded into the result register.
// Reset clears bridge_on, bank, cart enable and the reset phase, and empties both stages.
// A stalled result holds in the output register while one more access waits in the input
// register; beyond that s_axis_tready drops.
`default_nettype none
module cartridge_bridge_bank_registers (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	// [15:0] address, [23:16] write_data, [31:24] cart_read_data, [32] cart_present,
	// [39:33] zero
	input  wire  [39:0] s_axis_tdata,
	// [0] mode
	input  wire  [0:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	// [7:0] read_data, [23:8] cart_address, [24] cart_read, [25] cart_write,
	// [26] cart_power, [31:27] zero
	output logic [31:0] m_axis_tdata
);
	import cbbr_pkg::*;

	in_item_t  in_item;
	in_beat_t  beat_s1;
	out_item_t result;
	out_item_t out_item;
	logic      advance;

	// unpack the slave beat into the item fields
	assign in_item.mode           = mode_t'(s_axis_tuser[0]);
	assign in_item.address        = s_axis_tdata[15:0];
	assign in_item.write_data     = s_axis_tdata[23:16];
	assign in_item.cart_read_data = s_axis_tdata[31:24];
	assign in_item.cart_present   = s_axis_tdata[32];

	// advance the held access whenever the result register is free or being drained
	assign advance = beat_s1.valid && (!m_axis_tvalid || m_axis_tready);

	cbbr_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.advance  (advance),
		.beat_s1  (beat_s1)
	);

	cbbr_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (beat_s1.item),
		.advance (advance),
		.result  (result)
	);

	cbbr_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.result    (result),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_item  (out_item)
	);

	// pack the result fields, zero fill the top bits
	assign m_axis_tdata = {5'd0, out_item.cart_power, out_item.cart_write,
		out_item.cart_read, out_item.cart_address, out_item.read_data};

	// a forwarded access is either a read or a write, never both
	a_fwd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(out_item.cart_read && out_item.cart_write))
		else $error("cart_read and cart_write both set");

	// nothing forwarded means no cartridge address
	a_addr_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !out_item.cart_read && !out_item.cart_write)
		|-> out_item.cart_address == 16'd0)
		else $error("cart_address set on an unforwarded access");

	// a power pulse comes from a write, which returns no data and forwards nothing
	a_power_write: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && out_item.cart_power)
		|-> (out_item.read_data == 8'd0 && !out_item.cart_read && !out_item.cart_write))
		else $error("cart_power on a non-enable write");

	// back pressure at the input only while an access is waiting in the input register
	a_ready_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (beat_s1.valid && m_axis_tvalid && !m_axis_tready))
		else $error("input stalled without a full pipeline");

	// an advancing access always lands in the result register
	a_advance_load: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_axis_tvalid)
		else $error("advanced access lost");

endmodule
`default_nettype wire
